// File: src/cbd_pkg.sv
// Shared types and constants for the chunked body decoder.
// Holds the classified word passed from the front end to the back end.
// No dependencies.
`default_nettype none

package cbd_pkg;

	localparam int COUNT_W = 32;
	localparam int LIMIT_W = 32;
	localparam int CMP_W   = (COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W;
	localparam int QDEPTH  = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8388608);

	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_VT   = 8'h0B;
	localparam logic [7:0] CH_FF   = 8'h0C;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_SIZE  = 2'd1,
		ERR_LIMIT = 2'd2,
		ERR_CRLF  = 2'd3
	} err_t;

	typedef struct packed {
		logic       cmd;
		logic       is_lf;
		logic       is_cr;
		logic       is_blank;
		logic       is_hex;
		logic [3:0] hex_val;
		logic [7:0] raw;
	} cls_t;

	typedef struct packed {
		logic [1:0] error_code;
		logic       message_done;
		logic       body_valid;
		logic [7:0] body_byte;
	} res_t;

endpackage

`default_nettype wire

// File: src/cbd_front.sv
// Front end: takes stream words and classifies each byte.
// Depends on cbd_pkg for the classified word type.
`default_nettype none

module cbd_front (
	input  wire logic        command,
	input  wire logic [7:0]  stream_byte,
	output cbd_pkg::cls_t    cls
);

	always_comb begin
		cls          = '0;
		cls.cmd      = command;
		cls.raw      = stream_byte;
		cls.is_lf    = (stream_byte == cbd_pkg::CH_LF);
		cls.is_cr    = (stream_byte == cbd_pkg::CH_CR);
		cls.is_blank = (stream_byte == cbd_pkg::CH_SP) || (stream_byte == cbd_pkg::CH_TAB) ||
		               (stream_byte == cbd_pkg::CH_CR) || (stream_byte == cbd_pkg::CH_VT) ||
		               (stream_byte == cbd_pkg::CH_FF);
		if (stream_byte >= 8'h30 && stream_byte <= 8'h39) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = stream_byte[3:0];
		end else if ((stream_byte >= 8'h61 && stream_byte <= 8'h66) ||
		             (stream_byte >= 8'h41 && stream_byte <= 8'h46)) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = 4'(stream_byte[2:0] + 3'd1) + 4'd8;
		end
	end

endmodule

`default_nettype wire

// File: src/cbd_fifo.sv
// Short queue of classified words between front and back ends.
// Depends on cbd_pkg for the word type and depth.
`default_nettype none

module cbd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cbd_pkg::cls_t push_data,
	output logic               not_full,
	output logic               not_empty,
	input  wire logic          pop,
	output cbd_pkg::cls_t      pop_data
);

	localparam int PTR_W = (cbd_pkg::QDEPTH > 1) ? $clog2(cbd_pkg::QDEPTH) : 1;
	localparam int CNT_W = $clog2(cbd_pkg::QDEPTH + 1);

	cbd_pkg::cls_t    mem_q [cbd_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign not_full  = (count_q != CNT_W'(cbd_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(cbd_pkg::QDEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

`default_nettype wire

// File: src/cbd_back.sv
// Back end: decoder state machine, limit register and result register.
// Depends on cbd_pkg for the word, result and error types.
`default_nettype none

module cbd_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [cbd_pkg::LIMIT_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	input  wire cbd_pkg::cls_t                 in_cls,
	output logic                               in_pop,
	output logic                               res_valid,
	output cbd_pkg::res_t                      res,
	input  wire logic                          res_ready
);

	localparam int CW    = cbd_pkg::COUNT_W;
	localparam int SUM_W = cbd_pkg::CMP_W + 1;

	typedef enum logic [2:0] {
		PH_SIZE_WS,
		PH_SIZE_HEX,
		PH_SIZE_EXT,
		PH_DATA,
		PH_DATA_END,
		PH_DATA_CR,
		PH_TRAILER,
		PH_DONE
	} phase_t;

	phase_t                        phase_q, n_phase;
	logic [CW-1:0]                 acc_q, n_acc;
	logic                          digit_q, n_digit;
	logic [CW-1:0]                 left_q, n_left;
	logic [CW-1:0]                 total_q, n_total;
	logic                          nonblank_q, n_nonblank;
	cbd_pkg::err_t                 err_q, n_err;
	logic [cbd_pkg::LIMIT_W-1:0]   limit_q;
	logic                          res_valid_q;
	cbd_pkg::res_t                 res_q, n_res;
	logic                          over_limit;
	logic [SUM_W-1:0]              need;

	assign in_pop    = in_valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign need       = SUM_W'(total_q) + SUM_W'(acc_q);
	assign over_limit = (need > SUM_W'(limit_q));

	always_comb begin
		n_phase    = phase_q;
		n_acc      = acc_q;
		n_digit    = digit_q;
		n_left     = left_q;
		n_total    = total_q;
		n_nonblank = nonblank_q;
		n_err      = err_q;
		n_res      = '0;
		if (in_cls.cmd) begin
			n_phase    = PH_SIZE_WS;
			n_acc      = '0;
			n_digit    = 1'b0;
			n_left     = '0;
			n_total    = '0;
			n_nonblank = 1'b0;
			n_err      = cbd_pkg::ERR_NONE;
		end else if (err_q == cbd_pkg::ERR_NONE) begin
			unique case (phase_q)
				PH_SIZE_WS, PH_SIZE_HEX: begin
					if (in_cls.is_lf) begin
						if (!digit_q) begin
							n_err = cbd_pkg::ERR_SIZE;
						end else if (acc_q == '0) begin
							n_phase    = PH_TRAILER;
							n_nonblank = 1'b0;
						end else if (over_limit) begin
							n_err = cbd_pkg::ERR_LIMIT;
						end else begin
							n_left  = acc_q;
							n_phase = PH_DATA;
						end
						n_acc   = '0;
						n_digit = 1'b0;
					end else if (in_cls.is_hex) begin
						if (|acc_q[CW-1 -: 4]) begin
							n_acc = '1;
						end else begin
							n_acc = {acc_q[CW-5:0], in_cls.hex_val};
						end
						n_digit = 1'b1;
						n_phase = PH_SIZE_HEX;
					end else if (!(phase_q == PH_SIZE_WS && in_cls.is_blank)) begin
						n_phase = PH_SIZE_EXT;
					end
				end
				PH_SIZE_EXT: begin
					if (in_cls.is_lf) begin
						if (!digit_q) begin
							n_err = cbd_pkg::ERR_SIZE;
						end else if (acc_q == '0) begin
							n_phase    = PH_TRAILER;
							n_nonblank = 1'b0;
						end else if (over_limit) begin
							n_err = cbd_pkg::ERR_LIMIT;
						end else begin
							n_left  = acc_q;
							n_phase = PH_DATA;
						end
						n_acc   = '0;
						n_digit = 1'b0;
					end
				end
				PH_DATA: begin
					n_res.body_valid = 1'b1;
					n_res.body_byte  = in_cls.raw;
					n_total          = CW'(total_q + 1'b1);
					n_left           = CW'(left_q - 1'b1);
					if (left_q == CW'(1)) begin
						n_phase = PH_DATA_END;
					end
				end
				PH_DATA_END: begin
					if (in_cls.is_cr) begin
						n_phase = PH_DATA_CR;
					end else if (in_cls.is_lf) begin
						n_phase = PH_SIZE_WS;
					end else begin
						n_err = cbd_pkg::ERR_CRLF;
					end
				end
				PH_DATA_CR: begin
					if (in_cls.is_lf) begin
						n_phase = PH_SIZE_WS;
					end else begin
						n_err = cbd_pkg::ERR_CRLF;
					end
				end
				PH_TRAILER: begin
					if (in_cls.is_lf) begin
						if (!nonblank_q) begin
							n_phase = PH_DONE;
						end
						n_nonblank = 1'b0;
					end else if (!in_cls.is_blank) begin
						n_nonblank = 1'b1;
					end
				end
				PH_DONE: begin
				end
			endcase
		end
		n_res.message_done = (n_phase == PH_DONE) && (n_err == cbd_pkg::ERR_NONE);
		n_res.error_code   = n_err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIZE_WS;
			acc_q       <= '0;
			digit_q     <= 1'b0;
			left_q      <= '0;
			total_q     <= '0;
			nonblank_q  <= 1'b0;
			err_q       <= cbd_pkg::ERR_NONE;
			limit_q     <= cbd_pkg::LIMIT_RESET;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (in_pop) begin
				phase_q    <= n_phase;
				acc_q      <= n_acc;
				digit_q    <= n_digit;
				left_q     <= n_left;
				total_q    <= n_total;
				nonblank_q <= n_nonblank;
				err_q      <= n_err;
				res_q      <= n_res;
			end
			if (in_pop) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/chunked_body_decoder_top.sv
// Top level of the chunked body decoder: front end, queue and back end.
// Depends on cbd_pkg, cbd_front, cbd_fifo and cbd_back.
//
//   channel  direction  tdata / data                          tuser
//   s_       in         [7:0] stream_byte                     [0] command
//   m_       out        [7:0] body_byte, [8] message_done,    [0] body_valid
//                       [10:9] error_code, [15:11] zero
//   cfg_     in         [31:0] body_limit                     -
//
// One word in and one word out per cycle while m_ takes results; a word taken on s_
// passes a queue slot, then the result register, before it reaches m_.
// The back end state update is the loop that sets the rate.
// Reset clears all decoder state and loads body_limit with 8388608.
// A stall on m_ fills the two-slot queue, then drops s_tready.
`default_nettype none

module chunked_body_decoder_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,  // [7:0] stream_byte
	input  wire logic [0:0]   s_tuser,  // [0] command
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [15:0]       m_tdata,  // [7:0] body_byte, [8] message_done, [10:9] error_code
	output logic [0:0]        m_tuser,  // [0] body_valid
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [31:0]  cfg_data
);

	cbd_pkg::cls_t cls_in;
	cbd_pkg::cls_t cls_out;
	cbd_pkg::res_t res;
	logic          q_valid;
	logic          q_pop;

	assign cfg_ready = 1'b1;

	cbd_front u_front (
		.command     (s_tuser[0]),
		.stream_byte (s_tdata),
		.cls         (cls_in)
	);

	cbd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid),
		.push_data (cls_in),
		.not_full  (s_tready),
		.not_empty (q_valid),
		.pop       (q_pop),
		.pop_data  (cls_out)
	);

	cbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (q_valid),
		.in_cls    (cls_out),
		.in_pop    (q_pop),
		.res_valid (m_tvalid),
		.res       (res),
		.res_ready (m_tready)
	);

	assign m_tdata = {5'd0, res.error_code, res.message_done, res.body_byte};
	assign m_tuser = res.body_valid;

endmodule

`default_nettype wire

// File: src/cbd_checker.sv
// Port-level checks on the decoder result stream, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module cbd_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [15:0]  m_tdata,
	input wire logic [0:0]   m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_body_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[10:9] == 2'd0) && !m_tdata[8])
		else $error("body word with error or done flag");

	a_idle_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata[7:0] == 8'd0))
		else $error("non-body word carries a byte");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |-> (m_tdata[10:9] == 2'd0) && (m_tdata[15:11] == 5'd0))
		else $error("done flag with error code");

endmodule

bind chunked_body_decoder_top cbd_checker u_cbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// File: tb/tb_chunked_body_decoder_top.sv
// Self-checking testbench for chunked_body_decoder_top: directed table, then random messages.
// Each word taken on s_ is predicted by a model or the directed table and compared with m_.
// Depends on cbd_pkg and chunked_body_decoder_top.
`timescale 1ns / 1ps

module tb_chunked_body_decoder_top;

	localparam int RESET_CYCLES = 5;
	localparam int QUIET_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RAND_ITEMS   = 1300;
	localparam int N_PHASES     = 5;
	localparam logic [cbd_pkg::COUNT_W-1:0] COUNT_MAX = '1;
	localparam cbd_pkg::res_t RES_ZERO = '0;

	typedef enum logic [3:0] {
		P_SIZE_WS, P_SIZE_HEX, P_SIZE_EXT, P_DATA,
		P_DATA_END, P_DATA_CR, P_TRAILER, P_DONE
	} dec_phase_t;

	typedef struct packed {
		logic          cmd;
		logic [7:0]    b;
		logic          chk;
		cbd_pkg::res_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	// decoder model state
	dec_phase_t                      dm_phase;
	logic [cbd_pkg::COUNT_W-1:0]     dm_acc;
	logic                            dm_digit;
	logic [cbd_pkg::COUNT_W-1:0]     dm_left;
	logic [cbd_pkg::COUNT_W-1:0]     dm_total;
	logic                            dm_nonblank;
	cbd_pkg::err_t                   dm_err;
	logic [cbd_pkg::LIMIT_W-1:0]     dm_limit;

	cbd_pkg::res_t decoded_q[$];
	dir_row_t      dir_rows[$];
	int            mismatches;
	int            quiet_cycles;
	int            words_sent;
	logic          cur_chk;
	cbd_pkg::res_t cur_want;

	bit       tx_gaps;
	int       burst_left;
	int       rx_mode;
	logic [7:0] rx_pat;
	int       hold_req;
	int       hold_ack;
	int       hold_left;
	int       rx_tick;

	logic [7:0] ws_set[5];

	chunked_body_decoder_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic blank_char(input logic [7:0] c);
		return c == cbd_pkg::CH_SP || c == cbd_pkg::CH_TAB || c == cbd_pkg::CH_CR ||
		       c == cbd_pkg::CH_VT || c == cbd_pkg::CH_FF;
	endfunction

	function automatic void clear_decoder();
		dm_phase    = P_SIZE_WS;
		dm_acc      = '0;
		dm_digit    = 1'b0;
		dm_left     = '0;
		dm_total    = '0;
		dm_nonblank = 1'b0;
		dm_err      = cbd_pkg::ERR_NONE;
	endfunction

	function automatic void close_size_line();
		logic [cbd_pkg::CMP_W-1:0] t;
		logic [cbd_pkg::CMP_W-1:0] l;
		logic [cbd_pkg::CMP_W-1:0] s;
		t = cbd_pkg::CMP_W'(dm_total);
		l = cbd_pkg::CMP_W'(dm_limit);
		s = cbd_pkg::CMP_W'(dm_acc);
		if (!dm_digit) begin
			dm_err = cbd_pkg::ERR_SIZE;
		end else if (s == 0) begin
			dm_phase    = P_TRAILER;
			dm_nonblank = 1'b0;
		end else if (t > l || s > l - t) begin
			dm_err = cbd_pkg::ERR_LIMIT;
		end else begin
			dm_left  = dm_acc;
			dm_phase = P_DATA;
		end
		dm_acc   = '0;
		dm_digit = 1'b0;
	endfunction

	function automatic cbd_pkg::res_t decode_byte(input logic cmd, input logic [7:0] c);
		cbd_pkg::res_t r;
		logic is_hex;
		logic [3:0] dv;
		r = RES_ZERO;
		if (cmd) begin
			clear_decoder();
			return r;
		end
		is_hex = 1'b1;
		dv = 4'd0;
		if (c >= "0" && c <= "9") dv = 4'(c - "0");
		else if (c >= "a" && c <= "f") dv = 4'(c - "a" + 8'd10);
		else if (c >= "A" && c <= "F") dv = 4'(c - "A" + 8'd10);
		else is_hex = 1'b0;
		if (dm_err == cbd_pkg::ERR_NONE) begin
			case (dm_phase)
				P_SIZE_WS, P_SIZE_HEX: begin
					if (c == cbd_pkg::CH_LF) begin
						close_size_line();
					end else if (is_hex) begin
						if (dm_acc > (COUNT_MAX >> 4))
							dm_acc = COUNT_MAX;
						else
							dm_acc = (dm_acc << 4) | cbd_pkg::COUNT_W'(dv);
						dm_digit = 1'b1;
						dm_phase = P_SIZE_HEX;
					end else if (!(dm_phase == P_SIZE_WS && blank_char(c))) begin
						dm_phase = P_SIZE_EXT;
					end
				end
				P_SIZE_EXT: begin
					if (c == cbd_pkg::CH_LF) close_size_line();
				end
				P_DATA: begin
					r.body_valid = 1'b1;
					r.body_byte  = c;
					dm_total = dm_total + 1'b1;
					dm_left  = dm_left - 1'b1;
					if (dm_left == 0) dm_phase = P_DATA_END;
				end
				P_DATA_END: begin
					if (c == cbd_pkg::CH_CR) dm_phase = P_DATA_CR;
					else if (c == cbd_pkg::CH_LF) dm_phase = P_SIZE_WS;
					else dm_err = cbd_pkg::ERR_CRLF;
				end
				P_DATA_CR: begin
					if (c == cbd_pkg::CH_LF) dm_phase = P_SIZE_WS;
					else dm_err = cbd_pkg::ERR_CRLF;
				end
				P_TRAILER: begin
					if (c == cbd_pkg::CH_LF) begin
						if (!dm_nonblank) dm_phase = P_DONE;
						dm_nonblank = 1'b0;
					end else if (!blank_char(c)) begin
						dm_nonblank = 1'b1;
					end
				end
				default: ;
			endcase
		end
		r.message_done = (dm_phase == P_DONE && dm_err == cbd_pkg::ERR_NONE);
		r.error_code   = dm_err;
		return r;
	endfunction

	// model update and result check
	always @(posedge clk) begin
		cbd_pkg::res_t got;
		cbd_pkg::res_t want;
		cbd_pkg::res_t pred;
		if (!arst_n) begin
			clear_decoder();
			dm_limit = cbd_pkg::LIMIT_RESET;
			quiet_cycles = 0;
		end else begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (cfg_valid && cfg_ready)
				dm_limit = cfg_data[cbd_pkg::LIMIT_W-1:0];
			if (s_tvalid && s_tready) begin
				pred = decode_byte(s_tuser[0], s_tdata);
				if (cur_chk) pred = cur_want;
				decoded_q.push_back(pred);
			end
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[10:9], m_tdata[8], m_tuser[0], m_tdata[7:0]};
				if (decoded_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected word err=%0d done=%0b valid=%0b byte=%02h",
							$realtime, got.error_code, got.message_done, got.body_valid,
							got.body_byte);
				end else begin
					want = decoded_q.pop_front();
					if (got !== want || m_tdata[15:11] !== 5'd0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: exp %0d/%0b/%0b/%02h got %0d/%0b/%0b/%02h pad %02h",
								$realtime, want.error_code, want.message_done,
								want.body_valid, want.body_byte, got.error_code,
								got.message_done, got.body_valid, got.body_byte,
								m_tdata[15:11]);
					end
				end
			end
		end
	end

	// receiver: stall pattern, plus a long hold-off on request
	always @(negedge clk) begin
		rx_tick++;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_req != hold_ack) begin
			hold_ack  = hold_req;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= rx_pat[rx_tick % 8];
			endcase
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	// offer one word, hold until taken, then maybe open a gap
	task automatic feed(input logic cmd, input logic [7:0] b);
		int gap;
		s_tvalid = 1'b1;
		s_tdata  = b;
		s_tuser  = cmd;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		@(negedge clk);
		if (tx_gaps) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				gap = $urandom_range(1, 12);
				burst_left = $urandom_range(1, 16);
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (decoded_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(input logic [31:0] v);
		cfg_valid = 1'b1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [7:0] any_but(input logic [7:0] x, input logic [7:0] y);
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == x || b == y);
		return b;
	endfunction

	task automatic send_size_line(input logic [31:0] sz, input bit saturate);
		int nd;
		int i;
		logic [3:0] d;
		logic [31:0] v;
		repeat ($urandom_range(0, 2)) feed(1'b0, ws_set[$urandom_range(0, 4)]);
		if ($urandom_range(0, 14) != 0) begin
			nd = 1;
			v = sz >> 4;
			while (v != 0) begin
				nd++;
				v = v >> 4;
			end
			repeat ($urandom_range(0, 2)) feed(1'b0, "0");
			for (i = 0; i < (saturate ? 9 + $urandom_range(0, 1) : nd); i++) begin
				if (saturate) d = (i == 0) ? 4'(($urandom_range(1, 15))) : 4'($urandom);
				else d = sz[4*(nd-1-i) +: 4];
				if (d < 10) feed(1'b0, 8'("0" + d));
				else feed(1'b0, 8'(($urandom_range(0, 1) ? "A" : "a") + d - 10));
			end
		end
		if ($urandom_range(0, 3) == 0) begin
			feed(1'b0, $urandom_range(0, 1) ? cbd_pkg::CH_SEMI : 8'($urandom_range("g", "z")));
			repeat ($urandom_range(0, 3)) feed(1'b0, any_but(cbd_pkg::CH_LF, cbd_pkg::CH_LF));
		end
		feed(1'b0, cbd_pkg::CH_LF);
	endtask

	task automatic send_message();
		int k;
		int sz;
		int r;
		bit sat;
		if ($urandom_range(0, 9) < 7) feed(1'b1, 8'($urandom_range(0, 255)));
		for (k = $urandom_range(0, 3); k > 0; k--) begin
			sat = 1'b0;
			if ($urandom_range(0, 19) == 0) begin
				sat = $urandom_range(0, 1);
				sz = $urandom_range(13, 4000);
			end else begin
				sz = $urandom_range(1, 12);
			end
			send_size_line(sz, sat);
			repeat (sz > 12 ? $urandom_range(1, 20) : sz) feed(1'b0, 8'($urandom_range(0, 255)));
			r = $urandom_range(0, 19);
			if (r < 14) begin
				feed(1'b0, cbd_pkg::CH_CR);
				feed(1'b0, cbd_pkg::CH_LF);
			end else if (r < 17) begin
				feed(1'b0, cbd_pkg::CH_LF);
			end else if (r < 18) begin
				feed(1'b0, cbd_pkg::CH_CR);
				feed(1'b0, any_but(cbd_pkg::CH_LF, cbd_pkg::CH_LF));
			end else begin
				feed(1'b0, any_but(cbd_pkg::CH_CR, cbd_pkg::CH_LF));
			end
			if ($urandom_range(0, 19) == 0)
				repeat ($urandom_range(1, 3)) feed(1'b0, 8'($urandom_range(0, 255)));
		end
		send_size_line(0, 1'b0);
		repeat ($urandom_range(0, 2)) begin
			feed(1'b0, 8'($urandom_range("!", "~")));
			repeat ($urandom_range(0, 4)) feed(1'b0, any_but(cbd_pkg::CH_LF, cbd_pkg::CH_LF));
			feed(1'b0, cbd_pkg::CH_LF);
		end
		repeat ($urandom_range(0, 2)) feed(1'b0, ws_set[$urandom_range(0, 4)]);
		feed(1'b0, cbd_pkg::CH_LF);
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 2)) feed(1'b0, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		dir_row_t row;
		int ph;
		int target;
		clk        = 1'b0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		m_tready   = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		mismatches = 0;
		quiet_cycles = 0;
		words_sent = 0;
		cur_chk    = 1'b0;
		cur_want   = RES_ZERO;
		tx_gaps    = 1'b0;
		burst_left = 0;
		rx_mode    = 0;
		rx_pat     = 8'hFF;
		hold_req   = 0;
		hold_ack   = 0;
		hold_left  = 0;
		rx_tick    = 0;
		ws_set     = '{cbd_pkg::CH_SP, cbd_pkg::CH_TAB, cbd_pkg::CH_CR, cbd_pkg::CH_VT,
		               cbd_pkg::CH_FF};

		// chunk of two bytes with extension, then zero chunk and trailers
		dir_rows.push_back('{1'b1, 8'hA5,            1'b1, RES_ZERO});
		dir_rows.push_back('{1'b0, cbd_pkg::CH_TAB,  1'b0, RES_ZERO});
		dir_rows.push_back('{1'b0, "2",              1'b0, RES_ZERO});
		dir_rows.push_back('{1'b0, cbd_pkg::CH_SEMI, 1'b0, RES_ZERO});
		dir_rows.push_back('{1'b0, "z",              1'b0, RES_ZERO});
		dir_rows.push_back('{1'b0, cbd_pkg::CH_LF,   1'b0, RES_ZERO});
		dir_rows.push_back('{1'b0, 8'h00, 1'b1, '{cbd_pkg::ERR_NONE, 1'b0, 1'b1, 8'h00}});
		dir_rows.push_back('{1'b0, 8'hFF, 1'b1, '{cbd_pkg::ERR_NONE, 1'b0, 1'b1, 8'hFF}});
		dir_rows.push_back('{1'b0, cbd_pkg::CH_CR,   1'b0, RES_ZERO});
		dir_rows.push_back('{1'b0, cbd_pkg::CH_LF,   1'b0, RES_ZERO});
		dir_rows.push_back('{1'b0, "0",              1'b0, RES_ZERO});
		dir_rows.push_back('{1'b0, cbd_pkg::CH_LF,   1'b0, RES_ZERO});
		dir_rows.push_back('{1'b0, "X",              1'b0, RES_ZERO});
		dir_rows.push_back('{1'b0, cbd_pkg::CH_LF,   1'b0, RES_ZERO});
		dir_rows.push_back('{1'b0, cbd_pkg::CH_VT,   1'b0, RES_ZERO});
		dir_rows.push_back('{1'b0, cbd_pkg::CH_LF,
			1'b1, '{cbd_pkg::ERR_NONE, 1'b1, 1'b0, 8'h00}});
		dir_rows.push_back('{1'b0, "q", 1'b1, '{cbd_pkg::ERR_NONE, 1'b1, 1'b0, 8'h00}});
		// size line with no digits, then sticky error
		dir_rows.push_back('{1'b1, 8'h00,            1'b1, RES_ZERO});
		dir_rows.push_back('{1'b0, cbd_pkg::CH_LF,
			1'b1, '{cbd_pkg::ERR_SIZE, 1'b0, 1'b0, 8'h00}});
		dir_rows.push_back('{1'b0, "5", 1'b1, '{cbd_pkg::ERR_SIZE, 1'b0, 1'b0, 8'h00}});
		// CR after data not followed by LF
		dir_rows.push_back('{1'b1, 8'hFF,            1'b1, RES_ZERO});
		dir_rows.push_back('{1'b0, "1",              1'b0, RES_ZERO});
		dir_rows.push_back('{1'b0, cbd_pkg::CH_LF,   1'b0, RES_ZERO});
		dir_rows.push_back('{1'b0, "A", 1'b1, '{cbd_pkg::ERR_NONE, 1'b0, 1'b1, "A"}});
		dir_rows.push_back('{1'b0, cbd_pkg::CH_CR,   1'b0, RES_ZERO});
		dir_rows.push_back('{1'b0, "x", 1'b1, '{cbd_pkg::ERR_CRLF, 1'b0, 1'b0, 8'h00}});
		// stray byte right after data
		dir_rows.push_back('{1'b1, 8'h00,            1'b1, RES_ZERO});
		dir_rows.push_back('{1'b0, "1",              1'b0, RES_ZERO});
		dir_rows.push_back('{1'b0, cbd_pkg::CH_LF,   1'b0, RES_ZERO});
		dir_rows.push_back('{1'b0, "b",              1'b0, RES_ZERO});
		dir_rows.push_back('{1'b0, "y", 1'b1, '{cbd_pkg::ERR_CRLF, 1'b0, 1'b0, 8'h00}});

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			cur_chk  = row.chk;
			cur_want = row.want;
			feed(row.cmd, row.b);
		end
		cur_chk = 1'b0;
		words_sent = 0;

		for (ph = 0; ph < N_PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: ;
				1: write_limit(32'd0);
				2: write_limit(32'hFFFF_FFFF);
				3: write_limit(32'd20);
				default: write_limit($urandom_range(0, 200));
			endcase
			tx_gaps = (ph % 2 == 1) || ph == 4;
			rx_mode = ph % 3;
			rx_pat  = 8'($urandom_range(1, 255));
			if (ph == 2) hold_req++;
			target = RAND_ITEMS * (ph + 1) / N_PHASES;
			while (words_sent < target) send_message();
		end

		wait_idle();
		repeat (4) @(negedge clk);
		if (mismatches == 0 && decoded_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
